[hdl/srcf_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the CRC-8 byte fold for the sensor record framer.
// No dependencies; imported by srcf_crc_pipe and sensor_record_crc8_framer.
package srcf_pkg;

  localparam int FRAME_LEN   = 17;
  localparam int PAYLOAD_LEN = 15;
  localparam int CRC_STAGES  = 4;
  localparam int IDX_W       = $clog2(FRAME_LEN);

  localparam logic [7:0] CRC_POLY_REFL = 8'h8C;
  localparam logic [7:0] CRC_INIT      = 8'h00;
  localparam logic [7:0] TOKEN_RESET   = 8'h25;  // '%'

  // Configuration register indexes
  localparam logic CFG_START_TOKEN = 1'b0;
  localparam logic CFG_CRC_COVERS  = 1'b1;

  typedef enum logic [1:0] {
    KIND_START   = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_CRC     = 2'd2
  } byte_kind_t;

  typedef logic [PAYLOAD_LEN-1:0][7:0] payload_t;

  // Record plus finished CRC, handed from the CRC pipe to the serializer
  typedef struct packed {
    payload_t   payload;
    logic [7:0] crc;
  } frame_t;

  // Maxim/Dallas CRC-8, reflected, one byte
  function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY_REFL;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

[hdl/srcf_crc_pipe.sv]
`timescale 1ns / 1ps
// Four-stage CRC-8 pipeline over the 15 payload bytes (and optionally the token).
// Depends on srcf_pkg.
module srcf_crc_pipe (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  srcf_pkg::payload_t in_payload,
  input  logic [7:0]         start_token,
  input  logic               crc_covers_start,
  output logic               out_valid,
  input  logic               out_ready,
  output srcf_pkg::frame_t   out_frame
);
  import srcf_pkg::*;

  // Stage s folds bytes 4s-1 .. 4s+2 (stage 0: token option plus bytes 0..2)
  logic     stage_valid [CRC_STAGES];
  payload_t stage_pay   [CRC_STAGES];
  logic [7:0] stage_crc [CRC_STAGES];
  logic     stage_ready [CRC_STAGES];
  logic [7:0] crc_next  [CRC_STAGES];

  // Ready chain: a stage moves when empty or when its successor moves
  always_comb begin
    stage_ready[CRC_STAGES-1] = !stage_valid[CRC_STAGES-1] || out_ready;
    for (int s = CRC_STAGES - 2; s >= 0; s--) begin
      stage_ready[s] = !stage_valid[s] || stage_ready[s+1];
    end
  end

  // Partial CRC per stage
  always_comb begin
    logic [7:0] c;
    payload_t   p;
    int         idx;
    for (int s = 0; s < CRC_STAGES; s++) begin
      if (s == 0) begin
        p = in_payload;
        c = crc_covers_start ? crc8_fold(CRC_INIT, start_token) : CRC_INIT;
      end else begin
        p = stage_pay[s-1];
        c = stage_crc[s-1];
      end
      for (int j = 0; j < 4; j++) begin
        idx = 4 * s - 1 + j;
        if (idx >= 0 && idx < PAYLOAD_LEN) c = crc8_fold(c, p[idx]);
      end
      crc_next[s] = c;
    end
  end

  // Stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < CRC_STAGES; s++) stage_valid[s] <= 1'b0;
    end else begin
      for (int s = 0; s < CRC_STAGES; s++) begin
        if (stage_ready[s]) begin
          stage_valid[s] <= (s == 0) ? in_valid : stage_valid[s-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < CRC_STAGES; s++) begin
      if (stage_ready[s]) begin
        stage_pay[s] <= (s == 0) ? in_payload : stage_pay[s-1];
        stage_crc[s] <= crc_next[s];
      end
    end
  end

  assign in_ready          = stage_ready[0];
  assign out_valid         = stage_valid[CRC_STAGES-1];
  assign out_frame.payload = stage_pay[CRC_STAGES-1];
  assign out_frame.crc     = stage_crc[CRC_STAGES-1];

endmodule

[hdl/sensor_record_crc8_framer.sv]
`timescale 1ns / 1ps
// Top level of the sensor record framer: config registers, serializer, output register.
// Depends on srcf_pkg and srcf_crc_pipe.
//
// Each accepted record becomes a 17-byte frame: start token, 15 little-endian payload
// bytes (node id, temperature, accel x/y/z, gyro x/y/z), then a Maxim/Dallas CRC-8
// (reflected 0x8C, init 0). The output byte serializer sends one byte per cycle while
// out_stall is low; records queue in the four CRC stages meanwhile, and frames follow
// each other with no gap. With an idle pipe the start token reaches the output through
// the four CRC stages, the serializer load and the output register, and its transfer
// happens at the next edge at the earliest. Configuration (start token, and whether the
// token enters the CRC) is written on a port that is always ready, and is meant to
// change only while the block is idle.
module sensor_record_crc8_framer (
  input  logic               clk,
  input  logic               rst,
  // record input
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         node_id,
  input  logic [15:0]        temperature_raw,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  // byte output
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic [1:0]         byte_kind,
  output logic               frame_end,
  // configuration writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [7:0]         cfg_data
);
  import srcf_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

  logic       start_token;
  logic [7:0] token;
  logic       crc_covers_start;

  payload_t   in_payload;
  logic       pipe_in_ready;
  logic       pipe_valid;
  logic       pipe_ready;
  frame_t     pipe_frame;

  logic             ser_valid;
  logic [IDX_W-1:0] ser_idx;
  frame_t           ser_frame;
  logic             ser_last;
  logic             out_free;
  logic [IDX_W-1:0] pay_idx;
  logic [7:0]       sel_byte;
  byte_kind_t       sel_kind;

  // Configuration registers
  assign cfg_ready   = 1'b1;
  assign start_token = 1'b0;
  always_ff @(posedge clk) begin
    if (rst) begin
      token            <= TOKEN_RESET;
      crc_covers_start <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START_TOKEN: token            <= cfg_data;
        CFG_CRC_COVERS:  crc_covers_start <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Pack record little-endian
  assign in_payload = {gyro_z, gyro_y, gyro_x, accel_z, accel_y, accel_x,
                       temperature_raw, node_id};

  srcf_crc_pipe u_crc_pipe (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (pipe_in_ready),
    .in_payload       (in_payload),
    .start_token      (token | {8{start_token}}),
    .crc_covers_start (crc_covers_start),
    .out_valid        (pipe_valid),
    .out_ready        (pipe_ready),
    .out_frame        (pipe_frame)
  );

  assign in_stall = !pipe_in_ready;

  // Serializer handshake
  assign out_free   = !out_valid || !out_stall;
  assign ser_last   = (ser_idx == LAST_IDX);
  assign pipe_ready = !ser_valid || (ser_last && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      ser_valid <= 1'b0;
      ser_idx   <= '0;
    end else if (pipe_valid && pipe_ready) begin
      ser_valid <= 1'b1;
      ser_idx   <= '0;
    end else if (ser_valid && out_free) begin
      if (ser_last) begin
        ser_valid <= 1'b0;
        ser_idx   <= '0;
      end else begin
        ser_idx <= ser_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_valid && pipe_ready) ser_frame <= pipe_frame;
  end

  // Byte select for the current frame position
  assign pay_idx = ser_idx - 1'b1;
  always_comb begin
    if (ser_idx == '0) begin
      sel_byte = token;
      sel_kind = KIND_START;
    end else if (ser_last) begin
      sel_byte = ser_frame.crc;
      sel_kind = KIND_CRC;
    end else begin
      sel_byte = ser_frame.payload[pay_idx[3:0]];
      sel_kind = KIND_PAYLOAD;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= ser_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && ser_valid) begin
      out_byte  <= sel_byte;
      byte_kind <= sel_kind;
      frame_end <= ser_last;
    end
  end

  // Checks
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    ser_valid |-> ser_idx <= LAST_IDX)
    else $error("serializer index past end of frame");

  a_end_is_crc: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_end |-> byte_kind == KIND_CRC)
    else $error("frame end on a byte that is not the CRC");

  a_load_at_boundary: assert property (@(posedge clk) disable iff (rst)
    pipe_valid && pipe_ready |-> !ser_valid || ser_last)
    else $error("new frame loaded in the middle of a frame");

  a_start_follows_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && frame_end && ser_valid |=> out_valid && byte_kind == KIND_START)
    else $error("next frame does not open with the start token");

endmodule
